@@ src/slot_allocator_fifo_recycle_top_defines.svh @@
// Assertion macros shared by the slot allocator RTL.
// Each macro samples on aclk and is disabled while aresetn is low.
`ifndef SLOT_ALLOCATOR_FIFO_RECYCLE_TOP_DEFINES_SVH
`define SLOT_ALLOCATOR_FIFO_RECYCLE_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define SAFR_ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);
`define SAFR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);
`else
`define SAFR_ASSERT_IMPLY(lbl, ante, cons, msg)
`define SAFR_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

@@ src/safr_pkg.sv @@
// Package for the slot allocator: sizes, status codes, beat types and
// controller/datapath command and status types. Depends on nothing.
package safr_pkg;

    localparam int SLOT_CAPACITY = 64;
    localparam int IDX_W = $clog2(SLOT_CAPACITY);
    localparam int CNT_W = $clog2(SLOT_CAPACITY + 1);
    localparam int LIMIT_W = 7;
    localparam int CMP_W = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;
    localparam int SLOT_W = 6;
    localparam int STATUS_W = 3;

    localparam logic [LIMIT_W-1:0] SLOT_LIMIT_RESET = 7'd35;

    localparam logic FUNC_ALLOC = 1'b0;
    localparam logic FUNC_RELEASE = 1'b1;

    localparam logic [STATUS_W-1:0] ST_FRESH = 3'd0;
    localparam logic [STATUS_W-1:0] ST_REUSED = 3'd1;
    localparam logic [STATUS_W-1:0] ST_RECYCLED = 3'd2;
    localparam logic [STATUS_W-1:0] ST_RELEASED = 3'd3;
    localparam logic [STATUS_W-1:0] ST_IGNORED = 3'd4;

    typedef struct packed {
        logic              func;
        logic [SLOT_W-1:0] release_slot;
    } safr_in_t;

    typedef struct packed {
        logic [SLOT_W-1:0]   slot;
        logic [STATUS_W-1:0] status;
    } safr_out_t;

    typedef enum logic [3:0] {
        CMD_NONE,
        CMD_LOAD,
        CMD_FRESH,
        CMD_REUSE,
        CMD_RECYCLE,
        CMD_EMPTY,
        CMD_IGNORE,
        CMD_WALK_START,
        CMD_WALK,
        CMD_RELEASE
    } safr_op_e;

    typedef struct packed {
        safr_op_e op;
    } safr_cmd_t;

    typedef struct packed {
        logic is_release;
        logic free_avail;
        logic fresh_ok;
        logic age_avail;
        logic rel_ok;
        logic walk_done;
        logic out_free;
    } safr_stat_t;

    function automatic logic [IDX_W-1:0] ptr_inc(input logic [IDX_W-1:0] p);
        return (p == IDX_W'(SLOT_CAPACITY - 1)) ? '0 : p + 1'b1;
    endfunction

    function automatic logic [IDX_W-1:0] ptr_add(input logic [IDX_W-1:0] base,
                                                 input logic [CNT_W-1:0] off);
        logic [CNT_W:0] sum;
        sum = (CNT_W + 1)'(base) + (CNT_W + 1)'(off);
        if (sum >= (CNT_W + 1)'(SLOT_CAPACITY)) begin
            sum = sum - (CNT_W + 1)'(SLOT_CAPACITY);
        end
        return sum[IDX_W-1:0];
    endfunction

endpackage

@@ src/safr_ram.sv @@
// Generic single-clock RAM with one write port and one registered read port.
// Depends on nothing.
module safr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ src/safr_ctrl.sv @@
// Controller state machine of the slot allocator: sequences each request.
// Depends on safr_pkg.
module safr_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  safr_pkg::safr_stat_t stat,
    output safr_pkg::safr_cmd_t  cmd
);
    import safr_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_REUSE_RD,
        S_REUSE_WB,
        S_RECYC_RD,
        S_RECYC_WB,
        S_WALK,
        S_REL_DONE
    } state_t;

    state_t state_reg, state_next;
    logic   s_ready_reg;

    always_comb begin
        state_next = state_reg;
        cmd.op = CMD_NONE;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid && s_ready_reg) begin
                    cmd.op = CMD_LOAD;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                if (stat.is_release) begin
                    if (stat.rel_ok) begin
                        cmd.op = CMD_WALK_START;
                        state_next = S_WALK;
                    end else if (stat.out_free) begin
                        cmd.op = CMD_IGNORE;
                        state_next = S_IDLE;
                    end
                end else if (stat.free_avail) begin
                    state_next = S_REUSE_RD;
                end else if (stat.fresh_ok) begin
                    if (stat.out_free) begin
                        cmd.op = CMD_FRESH;
                        state_next = S_IDLE;
                    end
                end else if (stat.age_avail) begin
                    state_next = S_RECYC_RD;
                end else if (stat.out_free) begin
                    cmd.op = CMD_EMPTY;
                    state_next = S_IDLE;
                end
            end
            S_REUSE_RD: begin
                state_next = S_REUSE_WB;
            end
            S_REUSE_WB: begin
                if (stat.out_free) begin
                    cmd.op = CMD_REUSE;
                    state_next = S_IDLE;
                end
            end
            S_RECYC_RD: begin
                state_next = S_RECYC_WB;
            end
            S_RECYC_WB: begin
                if (stat.out_free) begin
                    cmd.op = CMD_RECYCLE;
                    state_next = S_IDLE;
                end
            end
            S_WALK: begin
                if (stat.walk_done) begin
                    state_next = S_REL_DONE;
                end else begin
                    cmd.op = CMD_WALK;
                end
            end
            S_REL_DONE: begin
                if (stat.out_free) begin
                    cmd.op = CMD_RELEASE;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            s_ready_reg <= 1'b1;
        end else begin
            state_reg <= state_next;
            s_ready_reg <= (state_next == S_IDLE);
        end
    end

    assign s_ready = s_ready_reg;

endmodule

@@ src/safr_dp.sv @@
// Datapath of the slot allocator: counters, pointers, in-use map, the free
// FIFO and age list RAMs, and the output register. Depends on safr_pkg and safr_ram.
`include "slot_allocator_fifo_recycle_top_defines.svh"
module safr_dp (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_we,
    input  logic [safr_pkg::LIMIT_W-1:0] cfg_wdata,
    input  safr_pkg::safr_in_t          s_data,
    input  safr_pkg::safr_cmd_t         cmd,
    output safr_pkg::safr_stat_t        stat,
    input  logic                        m_ready,
    output logic                        m_valid,
    output safr_pkg::safr_out_t         m_data
);
    import safr_pkg::*;

    logic [LIMIT_W-1:0]  slot_limit_reg;
    safr_in_t            req_reg;
    logic [CNT_W-1:0]    created_reg;
    logic [CNT_W-1:0]    free_count_reg;
    logic [CNT_W-1:0]    age_count_reg;
    logic [IDX_W-1:0]    free_head_reg;
    logic [IDX_W-1:0]    age_head_reg;
    logic [SLOT_CAPACITY-1:0] in_use_reg;
    logic [CNT_W-1:0]    walk_i_reg;
    logic [CNT_W-1:0]    walk_w_reg;
    logic                walk_pend_reg;
    logic                m_valid_reg;
    safr_out_t           m_data_reg;

    logic [IDX_W-1:0]    rel_idx;
    logic                rel_in_range;
    logic [LIMIT_W-1:0]  lim_eff;
    logic                walk_keep;
    logic [IDX_W-1:0]    created_idx;

    logic                free_we;
    logic [IDX_W-1:0]    free_waddr;
    logic [IDX_W-1:0]    free_rdata;
    logic                age_we;
    logic [IDX_W-1:0]    age_waddr;
    logic [IDX_W-1:0]    age_wdata;
    logic [IDX_W-1:0]    age_raddr;
    logic [IDX_W-1:0]    age_rdata;

    logic                emit;
    safr_out_t           out_next;

    assign rel_idx = IDX_W'(req_reg.release_slot);
    assign rel_in_range = CMP_W'(req_reg.release_slot) < CMP_W'(SLOT_CAPACITY);
    assign lim_eff = (slot_limit_reg == '0) ? LIMIT_W'(1) : slot_limit_reg;
    assign created_idx = created_reg[IDX_W-1:0];
    assign walk_keep = walk_pend_reg && (age_rdata != rel_idx);

    assign stat.is_release = (req_reg.func == FUNC_RELEASE);
    assign stat.free_avail = (free_count_reg != '0);
    assign stat.fresh_ok = ((CMP_W'(created_reg) < CMP_W'(lim_eff)) || (age_count_reg == '0))
                           && (created_reg < CNT_W'(SLOT_CAPACITY));
    assign stat.age_avail = (age_count_reg != '0);
    assign stat.rel_ok = rel_in_range && in_use_reg[rel_idx]
                         && (free_count_reg < CNT_W'(SLOT_CAPACITY));
    assign stat.walk_done = (walk_i_reg == age_count_reg) && !walk_pend_reg;
    assign stat.out_free = !m_valid_reg || m_ready;

    assign free_we = (cmd.op == CMD_RELEASE);
    assign free_waddr = ptr_add(free_head_reg, free_count_reg);
    assign age_raddr = (cmd.op == CMD_WALK) ? ptr_add(age_head_reg, walk_i_reg) : age_head_reg;

    always_comb begin
        age_we = 1'b0;
        age_waddr = ptr_add(age_head_reg, age_count_reg);
        age_wdata = age_rdata;
        case (cmd.op)
            CMD_FRESH: begin
                age_we = 1'b1;
                age_wdata = created_idx;
            end
            CMD_REUSE: begin
                age_we = 1'b1;
                age_wdata = free_rdata;
            end
            CMD_RECYCLE: begin
                age_we = 1'b1;
            end
            CMD_WALK: begin
                age_we = walk_keep;
                age_waddr = ptr_add(age_head_reg, walk_w_reg);
            end
            default: begin
                age_we = 1'b0;
            end
        endcase
    end

    always_comb begin
        emit = 1'b1;
        out_next.slot = req_reg.release_slot;
        out_next.status = ST_RELEASED;
        case (cmd.op)
            CMD_FRESH: begin
                out_next.slot = SLOT_W'(created_idx);
                out_next.status = ST_FRESH;
            end
            CMD_REUSE: begin
                out_next.slot = SLOT_W'(free_rdata);
                out_next.status = ST_REUSED;
            end
            CMD_RECYCLE: begin
                out_next.slot = SLOT_W'(age_rdata);
                out_next.status = ST_RECYCLED;
            end
            CMD_EMPTY: begin
                out_next.slot = '0;
                out_next.status = ST_RECYCLED;
            end
            CMD_IGNORE: begin
                out_next.status = ST_IGNORED;
            end
            CMD_RELEASE: begin
                out_next.status = ST_RELEASED;
            end
            default: begin
                emit = 1'b0;
            end
        endcase
    end

    safr_ram #(.WIDTH(IDX_W), .DEPTH(SLOT_CAPACITY)) u_free_ram (
        .aclk  (aclk),
        .we    (free_we),
        .waddr (free_waddr),
        .wdata (rel_idx),
        .raddr (free_head_reg),
        .rdata (free_rdata)
    );

    safr_ram #(.WIDTH(IDX_W), .DEPTH(SLOT_CAPACITY)) u_age_ram (
        .aclk  (aclk),
        .we    (age_we),
        .waddr (age_waddr),
        .wdata (age_wdata),
        .raddr (age_raddr),
        .rdata (age_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slot_limit_reg <= SLOT_LIMIT_RESET;
            created_reg <= '0;
            free_count_reg <= '0;
            age_count_reg <= '0;
            free_head_reg <= '0;
            age_head_reg <= '0;
            in_use_reg <= '0;
            walk_i_reg <= '0;
            walk_w_reg <= '0;
            walk_pend_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                slot_limit_reg <= cfg_wdata;
            end
            case (cmd.op)
                CMD_FRESH: begin
                    created_reg <= created_reg + 1'b1;
                    age_count_reg <= age_count_reg + 1'b1;
                    in_use_reg[created_idx] <= 1'b1;
                end
                CMD_REUSE: begin
                    free_head_reg <= ptr_inc(free_head_reg);
                    free_count_reg <= free_count_reg - 1'b1;
                    age_count_reg <= age_count_reg + 1'b1;
                    in_use_reg[free_rdata] <= 1'b1;
                end
                CMD_RECYCLE: begin
                    age_head_reg <= ptr_inc(age_head_reg);
                end
                CMD_WALK_START: begin
                    walk_i_reg <= '0;
                    walk_w_reg <= '0;
                    walk_pend_reg <= 1'b0;
                end
                CMD_WALK: begin
                    if (walk_i_reg < age_count_reg) begin
                        walk_i_reg <= walk_i_reg + 1'b1;
                        walk_pend_reg <= 1'b1;
                    end else begin
                        walk_pend_reg <= 1'b0;
                    end
                    if (walk_keep) begin
                        walk_w_reg <= walk_w_reg + 1'b1;
                    end
                end
                CMD_RELEASE: begin
                    age_count_reg <= walk_w_reg;
                    free_count_reg <= free_count_reg + 1'b1;
                    in_use_reg[rel_idx] <= 1'b0;
                end
                default: begin
                    walk_pend_reg <= walk_pend_reg;
                end
            endcase
            if (emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.op == CMD_LOAD) begin
            req_reg <= s_data;
        end
        if (emit) begin
            m_data_reg <= out_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data = m_data_reg;

    `SAFR_ASSERT_IMPLY(a_count_sum, 1'b1, ((CNT_W + 1)'(free_count_reg) + (CNT_W + 1)'(age_count_reg)) == (CNT_W + 1)'(created_reg), "Free and in-use counts do not add up to the created count.")
    `SAFR_ASSERT_IMPLY(a_map_count, 1'b1, $countones(in_use_reg) == int'(age_count_reg), "In-use map population differs from the age list length.")
    `SAFR_ASSERT_IMPLY(a_walk_removes_one, cmd.op == CMD_RELEASE, (walk_w_reg + CNT_W'(1)) == age_count_reg, "Release walk did not remove exactly one entry.")
    `SAFR_ASSERT_IMPLY(a_emit_free, emit, !m_valid_reg || m_ready, "A result beat was loaded over one not yet taken.")
    `SAFR_ASSERT_NEXT(a_release_clears, cmd.op == CMD_RELEASE, !in_use_reg[$past(rel_idx)], "Released slot is still marked in use.")

endmodule

@@ src/slot_allocator_fifo_recycle_top.sv @@
// Slot allocator top level: controller plus datapath; depends on safr_pkg, safr_ctrl, safr_dp.
// A fresh grant, an empty recycle or an ignored release is registered from S_DISPATCH; a reuse
// or recycle first reads its RAM (S_REUSE_RD/S_RECYC_RD, then the _WB state), and a release first
// walks the age list (S_WALK, then S_REL_DONE). One request at a time: the next beat is accepted
// once the result is registered, and a result waits while the output holds a beat not yet taken.
// Reset clears the counts and the in-use map and loads slot_limit with 35; the RAMs are not cleared.
module slot_allocator_fifo_recycle_top (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_we,
    input  logic [safr_pkg::LIMIT_W-1:0] cfg_wdata,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  safr_pkg::safr_in_t           s_data,
    output logic                         m_valid,
    input  logic                         m_ready,
    output safr_pkg::safr_out_t          m_data
);
    import safr_pkg::*;

    safr_cmd_t  cmd;
    safr_stat_t stat;

    safr_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    safr_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_data    (s_data),
        .cmd       (cmd),
        .stat      (stat),
        .m_ready   (m_ready),
        .m_valid   (m_valid),
        .m_data    (m_data)
    );

endmodule

@@ dv/tb_top.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for slot_allocator_fifo_recycle_top: allocate and release beats
// with random idling on both channels, checked against a local slot pool model.
// Depends on safr_pkg and the slot allocator RTL.
module tb_top;
    import safr_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;

    logic                 aclk;
    logic                 aresetn = 1'b0;
    logic                 cfg_we = 1'b0;
    logic [LIMIT_W-1:0]   cfg_wdata = '0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    safr_in_t             s_data = '0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    safr_out_t            m_data;

    safr_in_t             request_queue[$];
    safr_out_t            grant_queue[$];
    safr_out_t            owed_grants[$];
    safr_out_t            inflight_grant;
    safr_out_t            want;

    logic [LIMIT_W-1:0]   limit_shadow = SLOT_LIMIT_RESET;
    int                   created_n = 0;
    logic [SLOT_W-1:0]    released_fifo[$];
    logic [SLOT_W-1:0]    age_order[$];
    bit                   slot_in_use[SLOT_CAPACITY];

    int                   send_wait = 0;
    int                   hold_off = 0;
    int                   quiet_cycles = 0;
    int                   fault_count = 0;
    bit                   calm_sender = 1'b0;
    bit                   calm_receiver = 1'b0;

    slot_allocator_fifo_recycle_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // Updates the pool state for one request and returns the grant it yields.
    function automatic safr_out_t predict_grant(safr_in_t req);
        safr_out_t   g;
        int unsigned lim;
        lim = (limit_shadow == 0) ? 1 : int'(limit_shadow);
        if (lim > SLOT_CAPACITY) begin
            lim = SLOT_CAPACITY;
        end
        g.slot = req.release_slot;
        if (req.func == FUNC_ALLOC) begin
            if (released_fifo.size() > 0) begin
                g.slot = released_fifo[0];
                released_fifo.delete(0);
                slot_in_use[g.slot] = 1'b1;
                if (age_order.size() < SLOT_CAPACITY) begin
                    age_order.insert(age_order.size(), g.slot);
                end
                g.status = ST_REUSED;
            end else if ((created_n < lim || age_order.size() == 0)
                         && created_n < SLOT_CAPACITY) begin
                g.slot = SLOT_W'(created_n);
                created_n++;
                slot_in_use[g.slot] = 1'b1;
                if (age_order.size() < SLOT_CAPACITY) begin
                    age_order.insert(age_order.size(), g.slot);
                end
                g.status = ST_FRESH;
            end else if (age_order.size() > 0) begin
                g.slot = age_order[0];
                age_order.delete(0);
                age_order.insert(age_order.size(), g.slot);
                g.status = ST_RECYCLED;
            end else begin
                g.slot = '0;
                g.status = ST_RECYCLED;
            end
        end else if (slot_in_use[req.release_slot]
                     && released_fifo.size() < SLOT_CAPACITY) begin
            for (int i = age_order.size() - 1; i >= 0; i--) begin
                if (age_order[i] == req.release_slot) begin
                    age_order.delete(i);
                end
            end
            slot_in_use[req.release_slot] = 1'b0;
            released_fifo.insert(released_fifo.size(), req.release_slot);
            g.status = ST_RELEASED;
        end else begin
            g.status = ST_IGNORED;
        end
        return g;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(99);
        if (r < 55) begin
            return 0;
        end
        if (r < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    task automatic post(input logic func, input logic [SLOT_W-1:0] sl);
        safr_in_t req;
        req.func = func;
        req.release_slot = sl;
        request_queue.insert(request_queue.size(), req);
        grant_queue.insert(grant_queue.size(), predict_grant(req));
    endtask

    task automatic drain();
        do begin
            @(posedge aclk);
        end while (request_queue.size() != 0 || s_valid || owed_grants.size() != 0);
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_limit(input logic [LIMIT_W-1:0] v);
        drain();
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        limit_shadow = v;
        @(posedge aclk);
        cfg_we <= 1'b0;
        @(negedge aclk);
    endtask

    // Random allocates and releases, alloc_pct percent allocates; releases mostly name slots in use.
    task automatic run_phase(input logic [LIMIT_W-1:0] lim, input int alloc_pct,
                             input int count);
        logic              func;
        logic [SLOT_W-1:0] sl;
        write_limit(lim);
        calm_sender = ($urandom_range(2) == 0);
        calm_receiver = ($urandom_range(2) == 0);
        repeat (count) begin
            func = ($urandom_range(99) < alloc_pct) ? FUNC_ALLOC : FUNC_RELEASE;
            sl = SLOT_W'($urandom_range(63));
            if (func == FUNC_RELEASE && age_order.size() > 0 && $urandom_range(99) < 75) begin
                sl = age_order[$urandom_range(age_order.size() - 1)];
            end
            post(func, sl);
        end
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Releases with nothing in use, fresh grants, a release from the middle of the
        // age list, a repeated release, and reuse in release order.
        post(FUNC_RELEASE, 6'd0);
        post(FUNC_RELEASE, 6'd63);
        post(FUNC_ALLOC, 6'd63);
        post(FUNC_ALLOC, 6'd0);
        post(FUNC_ALLOC, 6'd21);
        post(FUNC_RELEASE, 6'd1);
        post(FUNC_RELEASE, 6'd1);
        post(FUNC_ALLOC, 6'd42);
        post(FUNC_RELEASE, 6'd0);
        post(FUNC_RELEASE, 6'd2);
        post(FUNC_ALLOC, 6'd0);
        post(FUNC_ALLOC, 6'd0);

        // A zero limit acts as one and sits below the created count, so grants recycle.
        write_limit(7'd0);
        post(FUNC_ALLOC, 6'd0);
        post(FUNC_ALLOC, 6'd0);
        post(FUNC_ALLOC, 6'd0);
        post(FUNC_RELEASE, 6'd1);
        post(FUNC_ALLOC, 6'd0);
        post(FUNC_ALLOC, 6'd0);

        // A limit above the pool size acts as the pool size.
        write_limit(7'd127);
        post(FUNC_ALLOC, 6'd0);
        post(FUNC_ALLOC, 6'd0);

        run_phase(7'd35, 65, 80);
        run_phase(7'd1, 55, 60);
        run_phase(7'd64, 90, 90);
        run_phase(7'd127, 95, 80);
        run_phase(7'd65, 50, 70);
        run_phase(7'd0, 50, 60);
        run_phase(LIMIT_W'($urandom_range(2, 126)), 50, 70);
        run_phase(7'd35, 45, 80);
        run_phase(LIMIT_W'($urandom_range(127)), 55, 60);

        drain();
        repeat (16) @(posedge aclk);
        if (fault_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                owed_grants.insert(owed_grants.size(), inflight_grant);
                send_wait = calm_sender ? 0 : pick_gap();
            end
            if (!s_valid || s_ready) begin
                if (send_wait > 0) begin
                    send_wait--;
                    s_valid <= 1'b0;
                end else if (request_queue.size() > 0) begin
                    s_valid <= 1'b1;
                    s_data <= request_queue[0];
                    request_queue.delete(0);
                    inflight_grant = grant_queue[0];
                    grant_queue.delete(0);
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (owed_grants.size() == 0) begin
                    $display("%0t: unexpected beat, slot %0d status %0d", $time,
                             m_data.slot, m_data.status);
                    fault_count++;
                end else begin
                    want = owed_grants[0];
                    owed_grants.delete(0);
                    if (m_data.slot !== want.slot) begin
                        $display("%0t: slot mismatch, expected %0d, actual %0d", $time,
                                 want.slot, m_data.slot);
                        fault_count++;
                    end
                    if (m_data.status !== want.status) begin
                        $display("%0t: status mismatch, expected %0d, actual %0d", $time,
                                 want.status, m_data.status);
                        fault_count++;
                    end
                end
            end
            if (hold_off > 0) begin
                hold_off--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
                if (!calm_receiver && $urandom_range(99) < 25) begin
                    hold_off = pick_gap();
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

endmodule
